### hdl/bpc_pkg.sv
// Shared types and constants of the button press classifier.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegDebounce   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLongPress  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDblWindow  = 2'd2;

  localparam logic [CfgDataW-1:0] DebounceRst  = 16'd50;
  localparam logic [CfgDataW-1:0] LongPressRst = 16'd1000;
  localparam logic [CfgDataW-1:0] DblWindowRst = 16'd300;

  // Timekeeping
  localparam int unsigned TimeW = 64;

  // Result queue
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  // Input item kind
  typedef enum logic {
    OpTick  = 1'b0,
    OpLevel = 1'b1
  } op_e;

  // Classified event
  typedef enum logic [1:0] {
    EvSingle = 2'd0,
    EvDouble = 2'd1,
    EvLong   = 2'd2
  } ev_e;

  // Results of one item handed to the queue: cnt of 0 to 2, ev_a first
  typedef struct packed {
    logic [1:0] cnt;
    ev_e        ev_a;
    ev_e        ev_b;
  } res_push_t;

endpackage

`default_nettype wire

### hdl/button_press_classifier.sv
// Top level of the button press classifier.
//
// Classifies one button into single, double and long presses.
// Input channel s_axis: one item per millisecond tick (tuser 0) or button
// level change (tuser 1, tdata[0] is the new level, 1 pressed).
// Output channel m_axis: one item per classified event, tdata[1:0] is
// 0 single, 1 double, 2 long; tlast marks the final event caused by one
// input item. Items that cause no event produce nothing.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 debounce ms, 1 long press ms, 2 double window ms); write only while idle.
// An item is registered at acceptance and processed once the result queue
// has room; its events are queued and then appear on m_axis in order.
// Throughput: one input item per cycle while the four-entry result queue
// has room for two results; the queue drains one event per cycle unless stalled.
// Reset clears all timers, counts and the queue and loads the register
// defaults 50, 1000 and 300. When the receiver stalls, events wait in the
// queue; s_axis_tready drops while an item waits in the input register and
// fewer than two queue entries are free.
`timescale 1ns / 1ps
`default_nettype none

module button_press_classifier (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [bpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bpc_pkg::CfgDataW-1:0] cfg_data_i,
  // input items
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // [0] pressed, [7:1] zero
  input  wire logic [0:0]                   s_axis_tuser,  // [0] op
  // result items
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [1:0] event_res, [7:2] zero
  output logic                              m_axis_tlast
);
  import bpc_pkg::*;

  logic      room;
  res_push_t push;
  ev_e       out_ev;

  bpc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser[0]),
    .in_pressed_i (s_axis_tdata[0]),
    .room_i       (room),
    .push_o       (push)
  );

  bpc_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ev_o    (out_ev),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_ev};

endmodule

`default_nettype wire

### hdl/bpc_core.sv
// Input register, press state and classification logic.
`timescale 1ns / 1ps
`default_nettype none

module bpc_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [bpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bpc_pkg::CfgDataW-1:0]  cfg_data_i,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          in_op_i,
  input  wire logic                          in_pressed_i,
  // result queue
  input  wire logic                          room_i,
  output bpc_pkg::res_push_t                 push_o
);
  import bpc_pkg::*;

  // configuration registers
  logic [CfgDataW-1:0] deb_q, lpl_q, dw_q;

  // input register
  logic in_vld_q, in_vld_d;
  op_e  op_q;
  logic pressed_q;

  // press state
  logic [TimeW-1:0]    uptime_q, uptime_d;
  logic [TimeW-1:0]    lpt_q, lpt_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                held_q, held_d;
  logic                lp_q, lp_d;
  logic [CfgDataW-1:0] lr_q, lr_d;
  logic                wp_q, wp_d;
  logic [CfgDataW-1:0] wr_q, wr_d;

  logic      proc;
  logic      in_fire;
  res_push_t push;

  assign proc       = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || room_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_vld_d   = in_fire ? 1'b1 : (proc ? 1'b0 : in_vld_q);

  // write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= DebounceRst;
      lpl_q <= LongPressRst;
      dw_q  <= DblWindowRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDebounce:  deb_q <= cfg_data_i;
        RegLongPress: lpl_q <= cfg_data_i;
        RegDblWindow: dw_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // capture the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q      <= op_e'(in_op_i);
      pressed_q <= in_pressed_i;
    end
  end

  // advance the state for the registered item
  always_comb begin
    logic [CfgDataW-1:0] lr_dec;
    logic [CfgDataW-1:0] wr_dec;
    logic [TimeW-1:0]    since;
    logic                long_ev;
    logic                win_ev;
    ev_e                 win_kind;

    uptime_d = uptime_q;
    lpt_d    = lpt_q;
    cnt_d    = cnt_q;
    held_d   = held_q;
    lp_d     = lp_q;
    lr_d     = lr_q;
    wp_d     = wp_q;
    wr_d     = wr_q;
    long_ev  = 1'b0;
    win_ev   = 1'b0;
    win_kind = EvSingle;
    lr_dec   = (lr_q != '0) ? lr_q - 1'b1 : lr_q;
    wr_dec   = (wr_q != '0) ? wr_q - 1'b1 : wr_q;
    since    = uptime_q - lpt_q;

    if (proc) begin
      case (op_q)
        OpTick: begin
          uptime_d = uptime_q + 1'b1;
          // long timer goes first
          if (lp_q) begin
            lr_d = lr_dec;
            if (lr_dec == '0) begin
              lp_d = 1'b0;
              if (held_q) begin
                long_ev = 1'b1;
                cnt_d   = 2'd0;
                lpt_d   = '0;
              end
            end
          end
          // then the double-press window, on the count left by the long timer
          if (wp_q) begin
            wr_d = wr_dec;
            if (wr_dec == '0) begin
              wp_d = 1'b0;
              if (cnt_d == 2'd1) begin
                win_ev   = 1'b1;
                win_kind = EvSingle;
              end else if (cnt_d == 2'd2) begin
                win_ev   = 1'b1;
                win_kind = EvDouble;
              end
              cnt_d = 2'd0;
              lpt_d = '0;
            end
          end
        end
        OpLevel: begin
          if (pressed_q) begin
            // accept a press outside the debounce time
            if (since >= TimeW'(deb_q)) begin
              held_d = 1'b1;
              lpt_d  = uptime_q;
              if (cnt_q != 2'd3) begin
                cnt_d = cnt_q + 1'b1;
              end
              if (!lp_q) begin
                lp_d = 1'b1;
                lr_d = (lpl_q == '0) ? CfgDataW'(1) : lpl_q;
              end
            end
          end else begin
            // release: a running long timer turns into the window
            held_d = 1'b0;
            if (lp_q) begin
              lp_d = 1'b0;
              lr_d = '0;
              wp_d = 1'b1;
              wr_d = (dw_q == '0) ? CfgDataW'(1) : dw_q;
            end
          end
        end
        default: ;
      endcase
    end

    push.cnt  = {1'b0, long_ev} + {1'b0, win_ev};
    push.ev_a = long_ev ? EvLong : win_kind;
    push.ev_b = win_kind;
  end

  assign push_o = push;

  // hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uptime_q <= '0;
      lpt_q    <= '0;
      cnt_q    <= '0;
      held_q   <= 1'b0;
      lp_q     <= 1'b0;
      lr_q     <= '0;
      wp_q     <= 1'b0;
      wr_q     <= '0;
    end else begin
      uptime_q <= uptime_d;
      lpt_q    <= lpt_d;
      cnt_q    <= cnt_d;
      held_q   <= held_d;
      lp_q     <= lp_d;
      lr_q     <= lr_d;
      wp_q     <= wp_d;
      wr_q     <= wr_d;
    end
  end

  // a running timer never sits at zero
  a_long_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lp_q |-> (lr_q != '0))
    else $error("long timer pending with zero count");

  a_win_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q |-> (wr_q != '0))
    else $error("window pending with zero count");

  // two results from one item are always long then a window result
  a_two_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd2) |-> (push.ev_a == EvLong && push.ev_b != EvLong))
    else $error("two results in wrong order");

  // results only come from a processed item
  a_push_proc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> (proc && op_q == OpTick))
    else $error("results without a processed tick");

endmodule

`default_nettype wire

### hdl/bpc_res_fifo.sv
// Result queue: per cycle up to two results in, one out if ready.
`timescale 1ns / 1ps
`default_nettype none

module bpc_res_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  bpc_pkg::res_push_t      push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output bpc_pkg::ev_e            out_ev_o,
  output logic                    out_last_o
);
  import bpc_pkg::*;

  ev_e                ev_q   [ResDepth];
  logic [ResDepth-1:0] last_q;
  logic [ResPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ResPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ResCntW-1:0] count_q, count_d;
  logic               pop;
  logic [ResPtrW-1:0] wr_ptr_nx;

  // keep room for the largest burst of one item
  assign room_o      = count_q <= ResCntW'(ResDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_ev_o    = ev_q[rd_ptr_q];
  assign out_last_o  = last_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_ptr_nx   = wr_ptr_q + 1'b1;

  // advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + ResPtrW'(push_i.cnt);
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + ResCntW'(push_i.cnt) - ResCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // store the results of one item, the final one marked last
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      ev_q[wr_ptr_q]   <= push_i.ev_a;
      last_q[wr_ptr_q] <= push_i.cnt == 2'd1;
    end
    if (push_i.cnt == 2'd2) begin
      ev_q[wr_ptr_nx]   <= push_i.ev_b;
      last_q[wr_ptr_nx] <= 1'b1;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> (count_q <= ResCntW'(ResDepth - 2)))
    else $error("result queue overflow");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ResCntW'(ResDepth))
    else $error("result count out of range");

  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pointers differ on empty queue");

endmodule

`default_nettype wire
